// ===== hw/rtl/rlld_pkg.sv =====
// ----------------------------------------------------------------------------
// Run-length line decoder package
// Item types, decoder phases and constants shared by the decoder files.
// ----------------------------------------------------------------------------
package rlld_pkg;

  localparam int unsigned LINE_W = 16;
  localparam int unsigned BYTE_W = 8;

  localparam logic [BYTE_W-1:0] CTRL_END       = 8'd128;
  localparam logic [BYTE_W:0]   REPEAT_BASE    = 9'd257;
  localparam logic [LINE_W-1:0] MIN_LINE_BYTES = 16'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] src_byte;
    logic              first_byte;
    logic              last_byte;
  } src_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic [LINE_W-1:0] length;
    logic              end_of_line;
    logic              end_of_data;
    logic              last_of_run;
  } seg_item_t;

  typedef enum logic [3:0] {
    PH_CTRL = 4'b0001,
    PH_LIT  = 4'b0010,
    PH_FILL = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  typedef struct packed {
    logic              emit;
    logic              done;
    seg_item_t         seg;
    logic [LINE_W-1:0] col_next;
    logic [BYTE_W-1:0] rem_next;
  } seg_step_t;

endpackage

// ===== hw/rtl/run_length_line_decoder_unit.sv =====
// Each source item is registered, and so is each segment built from it.
// Throughput: 1 source item per cycle when not stalled; an item yields one
// segment per cycle, so a repeat run cut into N line segments holds the source
// side until its last; the builder after the item register sets this figure.
// Reset: synchronous, active high; clears the decoder state, empties both
// registers and sets line_bytes to 4.
// ----------------------------------------------------------------------------
// Run-length line decoder
// Decodes PackBits-style source bytes into line-cut value/length segments.
// ----------------------------------------------------------------------------
module run_length_line_decoder_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        src_valid,
  output logic                        src_ready,
  input  rlld_pkg::src_item_t         src,
  output logic                        seg_valid,
  input  logic                        seg_ready,
  output rlld_pkg::seg_item_t         seg,
  input  logic                        cfg_we,
  input  logic [rlld_pkg::LINE_W-1:0] cfg_data
);
  import rlld_pkg::*;

  src_item_t         item;
  logic              item_valid;
  logic              started;
  logic [BYTE_W-1:0] rem;
  logic              pend;
  phase_t            phase;
  logic [BYTE_W-1:0] run_left;
  logic [LINE_W-1:0] column;
  logic [LINE_W-1:0] lb;

  phase_t            phase_next;
  logic [BYTE_W-1:0] run_left_next;
  logic              first_now;
  phase_t            ph_c;
  logic [BYTE_W-1:0] rl_c;
  logic [LINE_W-1:0] col_c;
  logic [BYTE_W-1:0] rem_c;
  logic              pend_c;
  logic [BYTE_W:0]   repeat_cnt;
  seg_step_t         step;
  logic              seg_free;
  logic              proceed;
  logic              src_fire;

  assign first_now  = !started && item.first_byte;
  assign ph_c       = first_now ? PH_CTRL : phase;
  assign rl_c       = first_now ? '0 : run_left;
  assign col_c      = first_now ? '0 : column;
  assign repeat_cnt = REPEAT_BASE - {1'b0, item.src_byte};

  always_comb begin
    phase_next    = phase;
    run_left_next = run_left;
    rem_c         = rem;
    pend_c        = pend;
    if (!started) begin
      phase_next    = ph_c;
      run_left_next = rl_c;
      rem_c         = '0;
      pend_c        = 1'b0;
      case (ph_c)
        PH_CTRL: begin
          if (item.src_byte == CTRL_END) begin
            pend_c = 1'b1;
          end else if (item.src_byte < CTRL_END) begin
            phase_next    = PH_LIT;
            run_left_next = item.src_byte + 8'd1;
            pend_c        = item.last_byte;
          end else begin
            phase_next    = PH_FILL;
            run_left_next = repeat_cnt[BYTE_W-1:0];
            pend_c        = item.last_byte;
          end
        end
        PH_LIT: begin
          rem_c         = 8'd1;
          run_left_next = rl_c - 8'd1;
          if (run_left_next == '0) begin
            phase_next = PH_CTRL;
          end
          pend_c = item.last_byte;
        end
        PH_FILL: begin
          rem_c         = rl_c;
          run_left_next = '0;
          phase_next    = PH_CTRL;
          pend_c        = item.last_byte;
        end
        default: begin
          pend_c = 1'b0;
        end
      endcase
      if (pend_c) begin
        phase_next    = PH_DONE;
        run_left_next = '0;
      end
    end
  end

  rlld_segment u_segment (
    .val  (item.src_byte),
    .rem  (rem_c),
    .pend (pend_c),
    .col  (col_c),
    .lb   (lb),
    .step (step)
  );

  assign seg_free  = !seg_valid || seg_ready;
  assign proceed   = item_valid && (!step.emit || seg_free);
  assign src_ready = !item_valid || (proceed && step.done);
  assign src_fire  = src_valid && src_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      started    <= 1'b0;
      phase      <= PH_CTRL;
      run_left   <= '0;
      column     <= '0;
      lb         <= MIN_LINE_BYTES;
      seg_valid  <= 1'b0;
    end else begin
      if (proceed) begin
        phase    <= phase_next;
        run_left <= run_left_next;
      end
      if (cfg_we) begin
        lb     <= (cfg_data < MIN_LINE_BYTES) ? MIN_LINE_BYTES : cfg_data;
        column <= '0;
      end else if (proceed) begin
        column <= step.col_next;
      end
      if (src_fire) begin
        item_valid <= 1'b1;
        started    <= 1'b0;
      end else if (proceed) begin
        started <= !step.done;
        if (step.done) begin
          item_valid <= 1'b0;
        end
      end
      if (proceed && step.emit) begin
        seg_valid <= 1'b1;
      end else if (seg_ready) begin
        seg_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (src_fire) begin
      item <= src;
    end
    if (proceed) begin
      rem  <= step.rem_next;
      pend <= pend_c;
    end
    if (proceed && step.emit) begin
      seg <= step.seg;
    end
  end

endmodule

// ===== hw/rtl/rlld_segment.sv =====
// ----------------------------------------------------------------------------
// Run-length line decoder segment builder
// Cuts the pending run at the line end and forms the next segment or end pad.
// ----------------------------------------------------------------------------
module rlld_segment (
  input  logic [rlld_pkg::BYTE_W-1:0] val,
  input  logic [rlld_pkg::BYTE_W-1:0] rem,
  input  logic                        pend,
  input  logic [rlld_pkg::LINE_W-1:0] col,
  input  logic [rlld_pkg::LINE_W-1:0] lb,
  output rlld_pkg::seg_step_t         step
);
  import rlld_pkg::*;

  logic [LINE_W-1:0] room;
  logic [LINE_W-1:0] rem_ext;
  logic [LINE_W-1:0] take;
  logic [LINE_W-1:0] col_sum;
  logic              eol;
  logic [BYTE_W-1:0] rem_after;
  logic              run_end;

  assign room      = lb - col;
  assign rem_ext   = {{(LINE_W-BYTE_W){1'b0}}, rem};
  assign take      = (rem_ext < room) ? rem_ext : room;
  assign col_sum   = col + take;
  assign eol       = (take == room);
  assign rem_after = rem - take[BYTE_W-1:0];
  assign run_end   = (rem_after == '0);

  always_comb begin
    step          = '0;
    step.col_next = col;
    step.rem_next = rem;
    if (rem != '0) begin
      step.emit            = 1'b1;
      step.seg.value       = val;
      step.seg.length      = take;
      step.seg.end_of_line = eol;
      step.seg.end_of_data = run_end && pend && eol;
      step.seg.last_of_run = run_end && (!pend || eol);
      step.done            = step.seg.last_of_run;
      step.col_next        = eol ? '0 : col_sum;
      step.rem_next        = rem_after;
    end else if (pend) begin
      step.emit            = 1'b1;
      step.done            = 1'b1;
      step.seg.end_of_data = 1'b1;
      step.seg.last_of_run = 1'b1;
      step.col_next        = '0;
      if (col != '0) begin
        step.seg.length      = room;
        step.seg.end_of_line = 1'b1;
      end
    end else begin
      step.done = 1'b1;
    end
  end

endmodule

// ===== hw/rtl/rlld_checker.sv =====
// ----------------------------------------------------------------------------
// Run-length line decoder checker
// Port-level checks on the segment channel, bound to the decoder top level.
// ----------------------------------------------------------------------------
module rlld_checker (
  input logic                clk,
  input logic                rst,
  input logic                seg_valid,
  input logic                seg_ready,
  input rlld_pkg::seg_item_t seg
);
  import rlld_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !seg_valid)
    else $error("segment valid right after reset");

  a_seg_hold: assert property (@(posedge clk) disable iff (rst)
    seg_valid && !seg_ready |=> seg_valid && $stable(seg))
    else $error("stalled segment changed");

  a_bare_mark: assert property (@(posedge clk) disable iff (rst)
    seg_valid && (seg.length == '0) |->
      seg.end_of_data && !seg.end_of_line && seg.last_of_run && (seg.value == '0))
    else $error("empty segment is not a bare end mark");

  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg.end_of_data |->
      seg.last_of_run && (seg.end_of_line || (seg.length == '0)))
    else $error("end of data does not close the line and the item");

endmodule

bind run_length_line_decoder_unit rlld_checker u_rlld_checker (
  .clk       (clk),
  .rst       (rst),
  .seg_valid (seg_valid),
  .seg_ready (seg_ready),
  .seg       (seg)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Run-length line decoder testbench
// Sends PackBits-style source bytes, predicts the line-cut segments from its
// own decoder state, and checks each segment against the oldest prediction.
// Directed end, restart, line-change cases, then random streams per width.
// ----------------------------------------------------------------------------
module tb;
  import rlld_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned TARGET_ITEMS = 440;

  typedef enum int {
    END_ON_MARK,
    END_ON_LAST_DATA,
    END_ON_LAST_CTRL,
    END_OPEN
  } stream_end_t;

  logic              clk;
  logic              rst;
  logic              src_valid;
  logic              src_ready;
  src_item_t         src;
  logic              seg_valid;
  logic              seg_ready;
  seg_item_t         seg;
  logic              cfg_we;
  logic [LINE_W-1:0] cfg_data;

  run_length_line_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src       (src),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .seg       (seg),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  phase_t            dec_phase;
  logic [BYTE_W-1:0] dec_left;
  logic [LINE_W-1:0] dec_col;
  logic [LINE_W-1:0] line_bytes_q;
  seg_item_t         step_segs[$];
  seg_item_t         pending_segs[$];

  int unsigned cycles;
  int unsigned errors;
  int unsigned decoded_items;
  int unsigned src_gap_max;
  int unsigned seg_gap_max;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("run_length_line_decoder_unit test failed");
      $finish;
    end
  end

  // Segments of one source byte, cut at line ends.
  task automatic cut_into_lines(input logic [BYTE_W-1:0] val, input int unsigned len,
                                input int unsigned lb);
    int unsigned left;
    int unsigned room;
    int unsigned take;
    seg_item_t s;
    left = len;
    while (left > 0) begin
      room = lb - dec_col;
      take = (left < room) ? left : room;
      s = '0;
      s.value = val;
      s.length = LINE_W'(take);
      s.end_of_line = (dec_col + take >= lb);
      dec_col = s.end_of_line ? '0 : LINE_W'(dec_col + take);
      step_segs.push_back(s);
      left -= take;
    end
  endtask

  task automatic close_stream(input int unsigned lb);
    seg_item_t s;
    s = '0;
    if (dec_col > 0) begin
      s.length = LINE_W'(lb - dec_col);
      s.end_of_line = 1'b1;
      s.end_of_data = 1'b1;
      step_segs.push_back(s);
      dec_col = '0;
    end else if (step_segs.size() > 0) begin
      step_segs[step_segs.size()-1].end_of_data = 1'b1;
    end else begin
      s.end_of_data = 1'b1;
      step_segs.push_back(s);
    end
    dec_phase = PH_DONE;
    dec_left = '0;
  endtask

  task automatic decode_src_byte(input src_item_t it);
    int unsigned lb;
    lb = (line_bytes_q < MIN_LINE_BYTES) ? MIN_LINE_BYTES : line_bytes_q;
    step_segs.delete();
    if (it.first_byte) begin
      dec_phase = PH_CTRL;
      dec_left = '0;
      dec_col = '0;
    end
    case (dec_phase)
      PH_CTRL: begin
        if (it.src_byte == CTRL_END) begin
          close_stream(lb);
        end else begin
          if (it.src_byte < CTRL_END) begin
            dec_phase = PH_LIT;
            dec_left = it.src_byte + 8'd1;
          end else begin
            dec_phase = PH_FILL;
            dec_left = BYTE_W'(REPEAT_BASE - it.src_byte);
          end
          if (it.last_byte) close_stream(lb);
        end
      end
      PH_LIT: begin
        cut_into_lines(it.src_byte, 1, lb);
        dec_left = dec_left - 8'd1;
        if (dec_left == 0) dec_phase = PH_CTRL;
        if (it.last_byte) close_stream(lb);
      end
      PH_FILL: begin
        cut_into_lines(it.src_byte, dec_left, lb);
        dec_left = '0;
        dec_phase = PH_CTRL;
        if (it.last_byte) close_stream(lb);
      end
      default: begin
      end
    endcase
    if (step_segs.size() > 0) step_segs[step_segs.size()-1].last_of_run = 1'b1;
    foreach (step_segs[i]) pending_segs.push_back(step_segs[i]);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic first, input logic last);
    int unsigned gap;
    src_item_t it;
    it.src_byte = b;
    it.first_byte = first;
    it.last_byte = last;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    src_valid <= 1'b1;
    src <= it;
    @(posedge clk);
    while (!src_ready) @(posedge clk);
    if (dec_phase != PH_DONE || first) decoded_items++;
    decode_src_byte(it);
    @(negedge clk);
  endtask

  task automatic drain();
    src_valid <= 1'b0;
    while (pending_segs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_line_bytes(input logic [LINE_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    line_bytes_q = v;
    dec_col = '0;
  endtask

  initial begin
    int unsigned gap;
    seg_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      gap = $urandom_range(0, seg_gap_max);
      if (gap > 0) begin
        seg_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      seg_ready <= 1'b1;
      @(posedge clk);
      while (!seg_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    seg_item_t want;
    if (!rst && seg_valid && seg_ready) begin
      if (pending_segs.size() == 0) begin
        $error("segment with no prediction: value %0d length %0d", seg.value, seg.length);
        errors++;
      end else begin
        want = pending_segs.pop_front();
        check_field("value", want.value, seg.value);
        check_field("length", want.length, seg.length);
        check_field("end_of_line", want.end_of_line, seg.end_of_line);
        check_field("end_of_data", want.end_of_data, seg.end_of_data);
        check_field("last_of_run", want.last_of_run, seg.last_of_run);
      end
    end
  end

  task automatic test_directed_runs();
    send_byte(8'h02, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hAA, 1'b0, 1'b0);
    send_byte(8'h81, 1'b0, 1'b0);
    send_byte(8'h55, 1'b0, 1'b0);
    send_byte(CTRL_END, 1'b0, 1'b0);
    send_byte(8'h33, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b1);
    send_byte(8'hFD, 1'b1, 1'b0);
    send_byte(8'h11, 1'b0, 1'b1);
    send_byte(CTRL_END, 1'b1, 1'b0);
    send_byte(8'h05, 1'b1, 1'b1);
    send_byte(8'h03, 1'b1, 1'b0);
    send_byte(8'h10, 1'b0, 1'b0);
    send_byte(8'h20, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h44, 1'b0, 1'b0);
    send_byte(CTRL_END, 1'b0, 1'b0);
  endtask

  task automatic test_line_change_mid_run();
    send_byte(8'h05, 1'b1, 1'b0);
    send_byte(8'h31, 1'b0, 1'b0);
    send_byte(8'h32, 1'b0, 1'b0);
    set_line_bytes(16'd6);
    send_byte(8'h33, 1'b0, 1'b0);
    send_byte(8'h34, 1'b0, 1'b0);
    send_byte(8'h35, 1'b0, 1'b0);
    send_byte(8'h36, 1'b0, 1'b0);
    send_byte(CTRL_END, 1'b0, 1'b0);
  endtask

  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 3);
    repeat (n) send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                         $urandom_range(0, 3) == 0);
  endtask

  task automatic send_stream();
    int unsigned runs;
    int unsigned len;
    logic [BYTE_W-1:0] ctrl;
    logic closing;
    stream_end_t end_kind;
    runs = $urandom_range(1, 6);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: end_kind = END_ON_MARK;
      4, 5, 6:    end_kind = END_ON_LAST_DATA;
      7:          end_kind = END_ON_LAST_CTRL;
      default:    end_kind = END_OPEN;
    endcase
    for (int r = 0; r < runs; r++) begin
      closing = (r == runs - 1);
      if ($urandom_range(0, 1)) begin
        len = ($urandom_range(0, 5) != 0) ? $urandom_range(1, 8) : $urandom_range(1, 128);
        ctrl = BYTE_W'(len - 1);
      end else begin
        len = 1;
        ctrl = BYTE_W'($urandom_range(129, 255));
      end
      if (closing && end_kind == END_ON_LAST_CTRL) begin
        send_byte(ctrl, r == 0, 1'b1);
        return;
      end
      send_byte(ctrl, r == 0, 1'b0);
      for (int i = 0; i < len; i++)
        send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0,
                  closing && end_kind == END_ON_LAST_DATA && i == len - 1);
    end
    if (end_kind == END_ON_MARK) send_byte(CTRL_END, 1'b0, 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0)
      send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_random_streams();
    logic [LINE_W-1:0] widths[10];
    int unsigned stop_at;
    widths = '{16'd4, 16'd0, 16'd5, 16'd65535, 16'd7, 16'd3, 16'd16, 16'd100,
               16'd1, 16'd4};
    foreach (widths[k]) begin
      set_line_bytes((k == 8) ? LINE_W'($urandom_range(4, 300)) : widths[k]);
      src_gap_max = (k % 3 == 2) ? 0 : 4;
      seg_gap_max = (k % 4 == 3) ? 0 : 4;
      stop_at = decoded_items + TARGET_ITEMS / 10;
      while (decoded_items < stop_at) begin
        if ($urandom_range(0, 6) == 0) send_noise();
        else send_stream();
      end
    end
    src_gap_max = 4;
    seg_gap_max = 4;
  endtask

  initial begin
    rst = 1'b1;
    src_valid = 1'b0;
    src = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    cycles = 0;
    errors = 0;
    decoded_items = 0;
    src_gap_max = 4;
    seg_gap_max = 4;
    dec_phase = PH_CTRL;
    dec_left = '0;
    dec_col = '0;
    line_bytes_q = MIN_LINE_BYTES;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_runs();
    test_line_change_mid_run();
    test_random_streams();
    drain();
    if (errors == 0) begin
      $display("run_length_line_decoder_unit test passed");
    end else begin
      $display("run_length_line_decoder_unit test failed");
    end
    $finish;
  end

endmodule
